[src/bmh_pkg.sv]
// Shared types and codes for the binary min-heap priority queue.
// No dependencies; used by binary_min_heap.
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [STATUS_W-1:0]     status_t;

  // operation codes carried on the input tuser
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[src/bmh_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies; the heap key store is an instance of it.
`timescale 1ns / 1ps
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and register both read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[src/binary_min_heap.sv]
// Channel  | Dir | tdata (low bit up)                                  | tuser
// s_axis   | in  | key[31:0]                                           | operation
// m_axis   | out | extracted, status, current_min, count, zero pad     | -
//
// One item at a time. Insert climbs level by level in S_UP (S_FIN if it reaches the root).
// Extract refills the root from S_LAST and descends in S_DOWN; each level is one
// registered read of the key RAM followed by compare and write-back.
// Errors (full/empty) go to S_DONE. A waiting result blocks only the next item's result.
// Synchronous reset clears the element count; the key RAM needs no clearing.
// Depends on bmh_pkg and bmh_ram.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap #(
  parameter int CAPACITY = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // key
  input  wire logic s_axis_tuser,         // operation
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // extracted[31:0], status[1:0], current_min[31:0], count, zero pad
  output logic [((2*bmh_pkg::KEY_W+bmh_pkg::STATUS_W+$clog2(CAPACITY+1)+7)/8)*8-1:0]
                    m_axis_tdata
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = AW + 2;
  localparam int OUT_W = ((2*bmh_pkg::KEY_W + bmh_pkg::STATUS_W + CNT_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DOWN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [AW-1:0]         pos, pos_next;
  bmh_pkg::key_t         cur, cur_next;
  bmh_pkg::key_t         root, root_next;
  bmh_pkg::key_t         res_extracted, res_extracted_next;
  bmh_pkg::status_t      res_status, res_status_next;

  bmh_pkg::key_t         out_extracted, out_min;
  bmh_pkg::status_t      out_status;
  logic [CNT_W-1:0]      out_count;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr_a, ram_raddr_b;
  bmh_pkg::key_t         ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [AW-1:0]         parent;
  logic [IW-1:0]         lc, rc;
  logic                  lc_ok, rc_ok, pick_r;
  bmh_pkg::key_t         child_val;
  logic [IW-1:0]         best;
  logic                  out_free;

  bmh_ram #(
    .WIDTH(bmh_pkg::KEY_W),
    .DEPTH(CAPACITY)
  ) u_key_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = OUT_W'({out_count, out_min, out_status, out_extracted});

  // tree neighbors of the current position
  assign parent    = (pos - AW'(1)) >> 1;
  assign lc        = IW'({pos, 1'b1});
  assign rc        = lc + IW'(1);
  assign lc_ok     = lc < IW'(count);
  assign rc_ok     = rc < IW'(count);
  assign pick_r    = rc_ok && (ram_rdata_b < ram_rdata_a);
  assign child_val = pick_r ? ram_rdata_b : ram_rdata_a;
  assign best      = pick_r ? rc : lc;

  // sequence one operation over the key RAM
  always_comb begin
    state_next         = state;
    count_next         = count;
    pos_next           = pos;
    cur_next           = cur;
    root_next          = root;
    res_extracted_next = res_extracted;
    res_status_next    = res_status;
    ram_we             = 1'b0;
    ram_waddr          = pos;
    ram_wdata          = cur;
    ram_raddr_a        = parent;
    ram_raddr_b        = AW'(rc);

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_extracted_next = '0;
          res_status_next    = bmh_pkg::ST_OK;
          state_next         = S_DONE;
          if (s_axis_tuser == bmh_pkg::OP_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = bmh_pkg::ST_FULL;
            end else if (count == '0) begin
              // first element goes straight to the root
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = s_axis_tdata;
              root_next  = s_axis_tdata;
              count_next = CNT_W'(1);
            end else begin
              cur_next    = s_axis_tdata;
              pos_next    = count[AW-1:0];
              count_next  = count + CNT_W'(1);
              ram_raddr_a = (count[AW-1:0] - AW'(1)) >> 1;
              state_next  = S_UP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = bmh_pkg::ST_EMPTY;
            end else begin
              res_extracted_next = root;
              count_next         = count - CNT_W'(1);
              if (count != CNT_W'(1)) begin
                // fetch the last element to refill the root
                ram_raddr_a = AW'(count - CNT_W'(1));
                state_next  = S_LAST;
              end
            end
          end
        end
      end

      S_UP: begin
        if (cur < ram_rdata_a) begin
          // move parent down into the hole, climb
          ram_we    = 1'b1;
          ram_wdata = ram_rdata_a;
          pos_next  = parent;
          if (parent == '0) begin
            state_next = S_FIN;
          end else begin
            ram_raddr_a = (parent - AW'(1)) >> 1;
          end
        end else begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end
      end

      S_LAST: begin
        cur_next    = ram_rdata_a;
        pos_next    = '0;
        ram_raddr_a = AW'(1);
        ram_raddr_b = AW'(2);
        state_next  = S_DOWN;
      end

      S_DOWN: begin
        if (lc_ok && (child_val < cur)) begin
          // lift the smaller child into the hole, descend
          ram_we      = 1'b1;
          ram_wdata   = child_val;
          pos_next    = AW'(best);
          ram_raddr_a = AW'({best, 1'b1});
          ram_raddr_b = AW'({best, 1'b1} + (IW + 1)'(1));
          if (pos == '0) begin
            root_next = child_val;
          end
        end else begin
          ram_we     = 1'b1;
          state_next = S_DONE;
          if (pos == '0) begin
            root_next = cur;
          end
        end
      end

      S_FIN: begin
        ram_we     = 1'b1;
        root_next  = cur;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold control state, the element count and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos           <= pos_next;
    cur           <= cur_next;
    root          <= root_next;
    res_extracted <= res_extracted_next;
    res_status    <= res_status_next;
    if (state == S_DONE && out_free) begin
      out_extracted <= res_extracted;
      out_status    <= res_status;
      out_min       <= (count == '0) ? '0 : root;
      out_count     <= count;
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for binary_min_heap: directed edge cases, fill/drain and random mixes.
// Depends on bmh_pkg and the binary_min_heap RTL; an internal heap predictor checks every word.
`timescale 1ns / 1ps

module testbench;

  localparam int HEAP_CAP = 256;
  localparam int COUNT_W  = $clog2(HEAP_CAP + 1);
  localparam int OUT_BITS = 2 * bmh_pkg::KEY_W + bmh_pkg::STATUS_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 60;

  localparam bmh_pkg::key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam bmh_pkg::key_t KEY_MIN = 32'sh8000_0000;

  typedef struct packed {
    bmh_pkg::key_t      extracted;
    bmh_pkg::status_t   status;
    bmh_pkg::key_t      current_min;
    logic [COUNT_W-1:0] count;
  } heap_result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic             s_tuser = bmh_pkg::OP_INSERT;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // predictor state
  bmh_pkg::key_t heap_keys [HEAP_CAP];
  int            heap_size;
  heap_result_t  expected_results [$];

  int error_count;
  int results_checked;
  int inserts_sent;
  int extracts_sent;
  int full_rejects;
  int empty_extracts;
  int peak_count;
  int cycle_count;
  int burst_left;

  binary_min_heap #(.CAPACITY(HEAP_CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // apply one operation to the predicted heap and return the expected result word
  function automatic heap_result_t apply_heap_op(input logic op, input bmh_pkg::key_t key);
    heap_result_t  res;
    int            pos;
    int            parent;
    int            best;
    int            lc;
    int            rc;
    bit            done;
    bmh_pkg::key_t tmp;
    res = '0;
    res.status = bmh_pkg::ST_OK;
    if (op == bmh_pkg::OP_INSERT) begin
      if (heap_size >= HEAP_CAP) begin
        res.status = bmh_pkg::ST_FULL;
      end else begin
        heap_keys[heap_size] = key;
        pos = heap_size;
        heap_size++;
        done = 1'b0;
        // climb while the parent is strictly larger
        while (!done && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_keys[pos] < heap_keys[parent]) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[parent];
            heap_keys[parent] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = bmh_pkg::ST_EMPTY;
      end else begin
        res.extracted = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        done = 1'b0;
        // descend toward the smaller child, left on a tie
        while (!done) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
          if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
          end
        end
      end
    end
    if (heap_size > 0) res.current_min = heap_keys[0];
    res.count = heap_size[COUNT_W-1:0];
    return res;
  endfunction

  // key mix: full range, tight range with repeats, and the signed extremes
  function automatic bmh_pkg::key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return bmh_pkg::key_t'($urandom);
    if (sel < 75) return bmh_pkg::key_t'($signed($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 6))
      0: return KEY_MIN;
      1: return KEY_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return KEY_MAX - 1;
      default: return KEY_MAX;
    endcase
  endfunction

  // send one word, record its prediction, then maybe open a gap between bursts
  task automatic send_item(input logic op, input bmh_pkg::key_t key);
    int           gap;
    heap_result_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = apply_heap_op(op, key);
    expected_results = {expected_results, pred};
    if (op == bmh_pkg::OP_INSERT) inserts_sent++;
    else extracts_sent++;
    if (heap_size > peak_count) peak_count = heap_size;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(1, $urandom_range(1, 12));
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stall pattern: modes held for random stretches
  always @(posedge clk) begin : drive_ready
    static rx_mode_t rx_mode = RX_OPEN;
    static int mode_left = 0;
    if (mode_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(30, 250);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
      default:  m_tready <= (mode_left % 7 == 0);
    endcase
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    heap_result_t exp_r;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word 0x%h with nothing pending", m_tdata));
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (m_tdata[31:0] !== exp_r.extracted)
          report_mismatch($sformatf("extracted %0d, want %0d", $signed(m_tdata[31:0]),
                                    exp_r.extracted));
        if (m_tdata[33:32] !== exp_r.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tdata[33:32], exp_r.status));
        if (m_tdata[65:34] !== exp_r.current_min)
          report_mismatch($sformatf("current_min %0d, want %0d", $signed(m_tdata[65:34]),
                                    exp_r.current_min));
        if (m_tdata[66 +: COUNT_W] !== exp_r.count)
          report_mismatch($sformatf("count %0d, want %0d", m_tdata[66 +: COUNT_W],
                                    exp_r.count));
        if (m_tdata[OUT_W-1:OUT_BITS] !== '0)
          report_mismatch($sformatf("pad bits 0x%h not zero", m_tdata[OUT_W-1:OUT_BITS]));
        if (exp_r.status == bmh_pkg::ST_FULL) full_rejects++;
        if (exp_r.status == bmh_pkg::ST_EMPTY) empty_extracts++;
      end
    end
  end

  // extract on a freshly reset heap
  task automatic test_empty_extract();
    send_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom));
    send_item(bmh_pkg::OP_EXTRACT, KEY_MAX);
  endtask

  // signed extremes, equal keys, drain past empty, reuse after emptying
  task automatic test_directed();
    bmh_pkg::key_t dir_keys [9];
    dir_keys = '{5, 3, 3, KEY_MAX, KEY_MIN, 0, -1, KEY_MIN + 1, 3};
    foreach (dir_keys[i]) send_item(bmh_pkg::OP_INSERT, dir_keys[i]);
    repeat (10) send_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom));
    send_item(bmh_pkg::OP_INSERT, KEY_MIN);
    send_item(bmh_pkg::OP_INSERT, KEY_MIN);
    send_item(bmh_pkg::OP_EXTRACT, KEY_MIN);
    send_item(bmh_pkg::OP_EXTRACT, 0);
  endtask

  // fill to capacity (deep climbs from a falling ramp), push past full, drain past empty
  task automatic test_fill_and_drain();
    bmh_pkg::key_t k;
    for (int i = 0; i < HEAP_CAP; i++) begin
      if ($urandom_range(0, 2) == 0) k = pick_key();
      else k = KEY_MAX - bmh_pkg::key_t'(i << 23) - bmh_pkg::key_t'($urandom_range(0, 255));
      send_item(bmh_pkg::OP_INSERT, k);
    end
    repeat (3) send_item(bmh_pkg::OP_INSERT, pick_key());
    send_item(bmh_pkg::OP_EXTRACT, pick_key());
    send_item(bmh_pkg::OP_INSERT, KEY_MIN);
    send_item(bmh_pkg::OP_INSERT, KEY_MAX);
    while (heap_size > 0) send_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom));
    send_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom));
  endtask

  // random mixes; the insert share varies per segment so the size wanders
  task automatic test_random_mix();
    int insert_pct;
    for (int seg = 0; seg < 11; seg++) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 25;
        1: insert_pct = 50;
        2: insert_pct = 65;
        default: insert_pct = 85;
      endcase
      repeat (100) begin
        if ($urandom_range(1, 100) <= insert_pct) send_item(bmh_pkg::OP_INSERT, pick_key());
        else send_item(bmh_pkg::OP_EXTRACT, bmh_pkg::key_t'($urandom));
      end
    end
  endtask

  initial begin
    heap_size  = 0;
    burst_left = $urandom_range(1, 40);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_extract();
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    s_tvalid <= 1'b0;

    // wait for outstanding results, then let the block settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts and %0d extracts; %0d result words checked",
             inserts_sent, extracts_sent, results_checked);
    $display("Full-heap rejects %0d, empty extracts %0d, peak heap size %0d",
             full_rejects, empty_extracts, peak_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
